/* rtl/lfis_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the LED fade instruction sequencer.
// No dependencies; imported by lfis_interp and the top level.
package lfis_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int LEVEL_W = 8;
	localparam int TICK_W = 16;
	localparam int PROD_W = LEVEL_W + TICK_W;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [LEVEL_W-1:0] target;
		logic [TICK_W-1:0]  fade;
		logic [TICK_W-1:0]  hold;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} interp_stat_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PUSH = 7'b0000010,
		S_READ = 7'b0000100,
		S_LOAD = 7'b0001000,
		S_STEP = 7'b0010000,
		S_WAIT = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

endpackage

/* rtl/lfis_interp.sv */
`timescale 1ns / 1ps
// Fade interpolation unit: one multiply, then an eight-step restoring divide.
// Depends on lfis_pkg.
module lfis_interp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lfis_pkg::TICK_W-1:0]   fade_left,
	input  logic [lfis_pkg::TICK_W-1:0]   fade_total,
	input  logic [lfis_pkg::LEVEL_W-1:0]  prev_level,
	input  logic [lfis_pkg::LEVEL_W-1:0]  cur_target,
	output logic [lfis_pkg::LEVEL_W-1:0]  result,
	output lfis_pkg::interp_stat_t        stat
);
	import lfis_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE = 4'b0001,
		P_MUL  = 4'b0010,
		P_DIV  = 4'b0100,
		P_FIN  = 4'b1000
	} phase_t;

	phase_t              phase_q;
	logic [2:0]          step_q;
	logic                done_q;
	logic                neg_q;
	logic [LEVEL_W-1:0]  mag_q;
	logic [LEVEL_W-1:0]  tgt_q;
	logic [TICK_W-1:0]   left_q;
	logic [TICK_W-1:0]   div_q;
	logic [TICK_W:0]     rem_q;
	logic [LEVEL_W-1:0]  num_q;
	logic [LEVEL_W-1:0]  quo_q;
	logic [LEVEL_W-1:0]  result_q;

	logic [LEVEL_W:0]    diff;
	logic [LEVEL_W:0]    diff_abs;
	logic [PROD_W-1:0]   prod;
	logic [TICK_W:0]     trial;
	logic [TICK_W:0]     trial_sub;
	logic                fits;

	assign diff      = {1'b0, prev_level} - {1'b0, cur_target};
	assign diff_abs  = diff[LEVEL_W] ? (~diff + 1'b1) : diff;
	assign prod      = PROD_W'(left_q) * PROD_W'(mag_q);
	assign trial     = {rem_q[TICK_W-1:0], num_q[LEVEL_W-1]};
	assign fits      = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) phase_q <= P_MUL;
				end
				P_MUL: begin
					step_q  <= '0;
					phase_q <= P_DIV;
				end
				P_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) phase_q <= P_FIN;
				end
				P_FIN: begin
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (start) begin
					neg_q  <= diff[LEVEL_W];
					mag_q  <= diff_abs[LEVEL_W-1:0];
					tgt_q  <= cur_target;
					left_q <= fade_left;
					div_q  <= fade_total;
				end
			end
			P_MUL: begin
				rem_q <= {1'b0, prod[PROD_W-1:LEVEL_W]};
				num_q <= prod[LEVEL_W-1:0];
				quo_q <= '0;
			end
			P_DIV: begin
				rem_q <= fits ? trial_sub : trial;
				num_q <= {num_q[LEVEL_W-2:0], 1'b0};
				quo_q <= {quo_q[LEVEL_W-2:0], fits};
			end
			P_FIN: begin
				result_q <= neg_q ? (tgt_q - quo_q) : (tgt_q + quo_q);
			end
			default: ;
		endcase
	end

	assign result = result_q;
	assign stat   = '{busy: (phase_q != P_IDLE), done: done_q};

endmodule

/* rtl/led_fade_instruction_sequencer.sv */
`timescale 1ns / 1ps
// A push goes through S_PUSH, S_EMIT; a loading tick through S_READ, S_LOAD, S_EMIT;
// a fading tick through S_STEP, S_WAIT (one multiply, eight divide steps in lfis_interp),
// S_EMIT; others S_EMIT. Commands stall until S_EMIT, held by res_stall, issues a result.
// Reset (arst_n low) empties the queue and clears engine and drive level; queue contents
// are not cleared.
// Depends on lfis_pkg and lfis_interp.
module led_fade_instruction_sequencer #(
	parameter int QUEUE_DEPTH = lfis_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          operation,
	input  logic [lfis_pkg::LEVEL_W-1:0]  target_level,
	input  logic [lfis_pkg::TICK_W-1:0]   fade_ticks,
	input  logic [lfis_pkg::TICK_W-1:0]   hold_ticks,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [lfis_pkg::LEVEL_W-1:0]  level,
	output logic                          level_written,
	output logic                          push_accepted,
	output logic                          engine_busy
);
	import lfis_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	state_t              state_q;
	entry_t              mem [QUEUE_DEPTH];
	entry_t              rd_data_q;
	entry_t              in_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                loaded_q;
	logic [LEVEL_W-1:0]  tgt_q;
	logic [TICK_W-1:0]   fade_left_q;
	logic [TICK_W-1:0]   fade_total_q;
	logic [TICK_W-1:0]   hold_left_q;
	logic [LEVEL_W-1:0]  prev_q;
	logic [LEVEL_W-1:0]  drive_q;
	logic                written_q;
	logic                accepted_q;
	logic                res_valid_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                level_written_q;
	logic                push_accepted_q;
	logic                engine_busy_q;

	logic                cmd_xfer;
	logic                slot_free;
	logic                interp_start;
	logic [LEVEL_W-1:0]  interp_result;
	interp_stat_t        interp_st;

	assign cmd_stall    = state_q != S_IDLE;
	assign cmd_xfer     = cmd_valid && !cmd_stall;
	assign slot_free    = !res_valid_q || !res_stall;
	assign interp_start = state_q == S_STEP;

	lfis_interp u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (interp_start),
		.fade_left  (fade_left_q),
		.fade_total (fade_total_q),
		.prev_level (prev_q),
		.cur_target (tgt_q),
		.result     (interp_result),
		.stat       (interp_st)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && cnt_q != CNT_W'(QUEUE_DEPTH)) mem[wr_ptr_q] <= in_q;
		rd_data_q <= mem[rd_ptr_q];
		if (cmd_xfer) begin
			in_q.target <= target_level;
			in_q.fade   <= fade_ticks;
			in_q.hold   <= hold_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			rd_ptr_q        <= '0;
			wr_ptr_q        <= '0;
			cnt_q           <= '0;
			loaded_q        <= 1'b0;
			tgt_q           <= '0;
			fade_left_q     <= '0;
			fade_total_q    <= '0;
			hold_left_q     <= '0;
			prev_q          <= '0;
			drive_q         <= '0;
			written_q       <= 1'b0;
			accepted_q      <= 1'b0;
			res_valid_q     <= 1'b0;
			level_q         <= '0;
			level_written_q <= 1'b0;
			push_accepted_q <= 1'b0;
			engine_busy_q   <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && state_q != S_EMIT) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_xfer) begin
						written_q  <= 1'b0;
						accepted_q <= 1'b0;
						if (operation == OP_PUSH) begin
							state_q <= S_PUSH;
						end else if (!loaded_q) begin
							state_q <= (cnt_q != '0) ? S_READ : S_EMIT;
						end else if (fade_left_q != '0) begin
							fade_left_q <= fade_left_q - TICK_W'(1);
							state_q     <= S_STEP;
						end else if (hold_left_q != '0) begin
							hold_left_q <= hold_left_q - TICK_W'(1);
							state_q     <= S_EMIT;
						end else begin
							prev_q   <= tgt_q;
							loaded_q <= 1'b0;
							state_q  <= S_EMIT;
						end
					end
				end
				S_PUSH: begin
					if (cnt_q != CNT_W'(QUEUE_DEPTH)) begin
						wr_ptr_q   <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
							: wr_ptr_q + PTR_W'(1);
						cnt_q      <= cnt_q + CNT_W'(1);
						accepted_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					tgt_q        <= rd_data_q.target;
					fade_left_q  <= rd_data_q.fade;
					fade_total_q <= rd_data_q.fade;
					hold_left_q  <= rd_data_q.hold;
					rd_ptr_q     <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
						: rd_ptr_q + PTR_W'(1);
					cnt_q        <= cnt_q - CNT_W'(1);
					loaded_q     <= 1'b1;
					if (rd_data_q.fade <= TICK_W'(1)) begin
						drive_q   <= rd_data_q.target;
						written_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_STEP: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (interp_st.done) begin
						drive_q   <= interp_result;
						written_q <= 1'b1;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						res_valid_q     <= 1'b1;
						level_q         <= drive_q;
						level_written_q <= written_q;
						push_accepted_q <= accepted_q;
						engine_busy_q   <= loaded_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign level         = level_q;
	assign level_written = level_written_q;
	assign push_accepted = push_accepted_q;
	assign engine_busy   = engine_busy_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_fade_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |-> fade_left_q <= fade_total_q)
		else $error("fade count above fade total");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		interp_st.done |-> state_q == S_WAIT)
		else $error("interpolation finished outside wait");
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside emit");
	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !interp_st.busy)
		else $error("interpolation busy while idle");
`endif

endmodule
